FILE: src/atrw_pkg.sv
// shared types, constants and helpers for the at response waiter
`timescale 1ns / 1ps

package atrw_pkg;

  localparam int PATTERN_BYTES = 8;
  localparam int STORE_DEPTH   = 1024;

  localparam int PAT_W   = 64;
  localparam int PLEN_W  = 4;
  localparam int TICK_W  = 32;
  localparam int CNT_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;

  localparam logic [TICK_W-1:0] GAP_LIMIT_RST = 32'd1000;
  localparam logic [SIZE_W-1:0] MAX_LEN_RST   = 11'd256;
  localparam logic [SIZE_W-1:0] STORE_DEPTH_C = SIZE_W'(STORE_DEPTH);
  localparam logic [PLEN_W-1:0] PAT_BYTES_C   = PLEN_W'(PATTERN_BYTES);
  localparam logic [TICK_W-1:0] TICK_MAX      = '1;
  localparam logic [BYTE_W-1:0] TERMINATOR    = 8'h00;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_WAITING  = 3'd0;
  localparam logic [STAT_W-1:0] ST_MATCHED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_GAP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd4;
  localparam logic [STAT_W-1:0] ST_IDLE     = 3'd5;

  // configuration register indexes
  localparam logic CFG_GAP_LIMIT = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  byte_count;
    logic [STAT_W-1:0] status;
    logic              success;
    logic              finished;
    logic [BYTE_W-1:0] store_byte;
    logic [CNT_W-1:0]  store_index;
    logic              store_valid;
  } res_t;

  // low len bytes set, len already limited to the pattern size
  function automatic logic [PAT_W-1:0] tail_mask(input logic [PLEN_W-1:0] len);
    logic [PAT_W-1:0] m;
    m = '0;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (PLEN_W'(i) < len) m[i*BYTE_W +: BYTE_W] = '1;
    end
    return m;
  endfunction

endpackage

FILE: src/at_response_waiter.sv
// top level of the modem response waiter
`timescale 1ns / 1ps

// Waits for a modem response and matches its tail against an expected
// pattern. Every input beat gives exactly one result beat. A start beat
// (tuser 0) opens a wait with an overall tick limit and up to 8 pattern
// bytes, last byte in the low bits; a pattern length of 0 means no-expect
// mode, where a gap or an overall timeout counts as success. A byte beat
// (tuser 1) writes the byte to the response store position reported in
// the result and compares the stored tail with the pattern. A tick beat
// (tuser 2) advances the overall timer and, after the first byte, the gap
// timer. The wait ends on match, overflow, gap or overall timeout; on all
// but a match the terminator 0 is reported at the byte count position.
// Throughput is one beat per clock while results are taken: the wait state
// and compare sit between the input handshake and a result register, and a
// skid entry behind that register keeps the input open for one more beat
// while a result is stalled. Config writes are taken at any time but are
// meant to land while idle.

module at_response_waiter
  import atrw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rx_byte[7:0], timeout_ticks[39:8], pattern[103:40], pattern_length[107:104]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      in_tuser,
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // store_valid[0], store_index[10:1], store_byte[18:11], finished[19],
  // success[20], status[23:21], byte_count[33:24]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // config writes: index 0 gap limit, 1 max response length
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);

  logic              push;
  logic              can_push;
  res_t              core_res;
  res_t              out_res;
  logic [TICK_W-1:0] gap_limit;
  logic [SIZE_W-1:0] max_len;

  assign in_tready = can_push;
  assign push      = in_tvalid && can_push;
  assign cfg_ready = 1'b1;

  atrw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .gap_limit(gap_limit),
    .max_len  (max_len)
  );

  atrw_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .req_type      (in_tuser),
    .rx_byte       (in_tdata[7:0]),
    .timeout_ticks (in_tdata[39:8]),
    .pattern       (in_tdata[103:40]),
    .pattern_length(in_tdata[107:104]),
    .gap_limit     (gap_limit),
    .max_len       (max_len),
    .res           (core_res)
  );

  atrw_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (core_res),
    .can_push (can_push),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  // struct packs store_valid into bit 0 up to byte_count at the top
  assign out_tdata = {(OUT_DATA_W - $bits(res_t))'(0), out_res};

endmodule

FILE: src/atrw_core.sv
// wait state, timers and pattern compare; builds one result per beat
`timescale 1ns / 1ps

module atrw_core
  import atrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [TICK_W-1:0] timeout_ticks,
  input  logic [PAT_W-1:0]  pattern,
  input  logic [PLEN_W-1:0] pattern_length,
  input  logic [TICK_W-1:0] gap_limit,
  input  logic [SIZE_W-1:0] max_len,
  output res_t              res
);

  logic              waiting_r, waiting_nxt;
  logic              seen_r, seen_nxt;
  logic [TICK_W-1:0] total_r, total_nxt;
  logic [TICK_W-1:0] gap_r, gap_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PAT_W-1:0]  recent_r, recent_nxt;
  logic [PAT_W-1:0]  want_r, want_nxt;
  logic [PLEN_W-1:0] wlen_r, wlen_nxt;
  logic [TICK_W-1:0] limit_r, limit_nxt;

  logic [PLEN_W-1:0] len_sat;
  logic [SIZE_W-1:0] size;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PAT_W-1:0]  shifted;
  logic [PAT_W-1:0]  mask;
  logic [TICK_W-1:0] total_inc;
  logic [TICK_W-1:0] gap_inc;
  logic              no_expect;
  logic              overflow;
  logic              match;

  always_comb begin
    len_sat   = (pattern_length > PAT_BYTES_C) ? PAT_BYTES_C : pattern_length;
    size      = (max_len > STORE_DEPTH_C) ? STORE_DEPTH_C : max_len;
    cnt_inc   = cnt_r + CNT_W'(1);
    shifted   = {recent_r[PAT_W-BYTE_W-1:0], rx_byte};
    mask      = tail_mask(wlen_r);
    total_inc = (total_r != TICK_MAX) ? total_r + TICK_W'(1) : total_r;
    gap_inc   = (seen_r && gap_r != TICK_MAX) ? gap_r + TICK_W'(1) : gap_r;
    no_expect = (wlen_r == '0);
    // size of 0 or 1 leaves no room at all
    overflow  = (size < SIZE_W'(2)) || ({1'b0, cnt_r} >= size - SIZE_W'(1));
    match     = !no_expect && ({1'b0, cnt_inc} >= SIZE_W'(wlen_r)) &&
                ((shifted & mask) == (want_r & mask));
  end

  always_comb begin
    waiting_nxt = waiting_r;
    seen_nxt    = seen_r;
    total_nxt   = total_r;
    gap_nxt     = gap_r;
    cnt_nxt     = cnt_r;
    recent_nxt  = recent_r;
    want_nxt    = want_r;
    wlen_nxt    = wlen_r;
    limit_nxt   = limit_r;

    res             = '0;
    res.byte_count  = cnt_r;
    res.status      = waiting_r ? ST_WAITING : ST_IDLE;

    priority if (req_type == REQ_START) begin
      waiting_nxt    = 1'b1;
      total_nxt      = '0;
      gap_nxt        = '0;
      seen_nxt       = 1'b0;
      cnt_nxt        = '0;
      recent_nxt     = '0;
      want_nxt       = pattern;
      wlen_nxt       = len_sat;
      limit_nxt      = timeout_ticks;
      res.byte_count = '0;
      res.status     = ST_WAITING;
      if (timeout_ticks == '0) begin
        // zero timeout ends the wait at once, terminator at index 0
        waiting_nxt     = 1'b0;
        res.store_valid = 1'b1;
        res.store_byte  = TERMINATOR;
        res.finished    = 1'b1;
        res.success     = (len_sat == '0);
        res.status      = ST_TIMEOUT;
      end
    end else if (!waiting_r || req_type == REQ_NONE) begin
      // ignored beat, defaults stand
    end else if (req_type == REQ_BYTE) begin
      seen_nxt = 1'b1;
      gap_nxt  = '0;
      if (overflow) begin
        waiting_nxt     = 1'b0;
        res.store_valid = 1'b1;
        res.store_index = cnt_r;
        res.store_byte  = TERMINATOR;
        res.finished    = 1'b1;
        res.status      = ST_OVERFLOW;
      end else begin
        cnt_nxt         = cnt_inc;
        recent_nxt      = shifted;
        res.store_valid = 1'b1;
        res.store_index = cnt_r;
        res.store_byte  = rx_byte;
        res.byte_count  = cnt_inc;
        if (match) begin
          waiting_nxt  = 1'b0;
          res.finished = 1'b1;
          res.success  = 1'b1;
          res.status   = ST_MATCHED;
        end
      end
    end else begin
      total_nxt = total_inc;
      gap_nxt   = gap_inc;
      if (total_inc >= limit_r) begin
        waiting_nxt     = 1'b0;
        res.store_valid = 1'b1;
        res.store_index = cnt_r;
        res.store_byte  = TERMINATOR;
        res.finished    = 1'b1;
        res.success     = no_expect;
        res.status      = ST_TIMEOUT;
      end else if (seen_r && gap_inc > gap_limit) begin
        waiting_nxt     = 1'b0;
        res.store_valid = 1'b1;
        res.store_index = cnt_r;
        res.store_byte  = TERMINATOR;
        res.finished    = 1'b1;
        res.success     = no_expect;
        res.status      = ST_GAP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      seen_r    <= 1'b0;
      total_r   <= '0;
      gap_r     <= '0;
      cnt_r     <= '0;
      recent_r  <= '0;
      want_r    <= '0;
      wlen_r    <= '0;
      limit_r   <= '0;
    end else if (push) begin
      waiting_r <= waiting_nxt;
      seen_r    <= seen_nxt;
      total_r   <= total_nxt;
      gap_r     <= gap_nxt;
      cnt_r     <= cnt_nxt;
      recent_r  <= recent_nxt;
      want_r    <= want_nxt;
      wlen_r    <= wlen_nxt;
      limit_r   <= limit_nxt;
    end
  end

endmodule

FILE: src/atrw_cfg.sv
// configuration registers: gap limit and maximum response length
`timescale 1ns / 1ps

module atrw_cfg
  import atrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [31:0]       wr_data,
  output logic [TICK_W-1:0] gap_limit,
  output logic [SIZE_W-1:0] max_len
);

  logic [TICK_W-1:0] gap_limit_r;
  logic [SIZE_W-1:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
      max_len_r   <= MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_GAP_LIMIT: gap_limit_r <= wr_data[TICK_W-1:0];
        CFG_MAX_LEN:   max_len_r   <= wr_data[SIZE_W-1:0];
        default:       ;
      endcase
    end
  end

  assign gap_limit = gap_limit_r;
  assign max_len   = max_len_r;

endmodule

FILE: src/atrw_skid.sv
// result register with one skid entry behind it
`timescale 1ns / 1ps

module atrw_skid
  import atrw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_v_r;
  logic skid_v_r;
  res_t out_d_r;
  res_t skid_d_r;
  logic pop;

  assign pop      = out_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || pop) begin
        out_v_r  <= skid_v_r || push;
        skid_v_r <= 1'b0;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_d_r <= skid_v_r ? skid_d_r : push_res;
    end else if (push) begin
      skid_d_r <= push_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

endmodule

FILE: src/atrw_checker.sv
// port-level checks for the at response waiter, bound to the top level
`timescale 1ns / 1ps

module atrw_checker
  import atrw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic              fin;
  logic              ok;
  logic              sv;
  logic [STAT_W-1:0] st;

  assign sv  = out_tdata[0];
  assign fin = out_tdata[19];
  assign ok  = out_tdata[20];
  assign st  = out_tdata[23:21];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_fin_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fin |-> sv)
    else $error("finished beat without a store write");

  a_ok_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ok |-> fin)
    else $error("success without finished");

  a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fin == (st == ST_MATCHED || st == ST_OVERFLOW ||
                            st == ST_GAP || st == ST_TIMEOUT)))
    else $error("finished flag and status disagree");

endmodule

bind at_response_waiter atrw_checker u_atrw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
